### sv/dbcs_pkg.sv
// Shared types and constants for the double-byte charset decoder.
// No dependencies; imported by dbcs_to_unicode_decoder and its testbench.
package dbcs_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int KEY_W     = 16;
    localparam int UNIT_W    = 16;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Packed stream widths
    localparam int S_TDATA_W = 40;  // data_byte + table_index + table_value
    localparam int M_TDATA_W = 32;  // code_unit + bad_bytes

    // Reset value of the missing-mapping marker
    localparam logic [UNIT_W-1:0] MISSING_MARKER_RST = 16'hFFFD;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_DATA     = 2'd0,
        FN_PRIMARY  = 2'd1,
        FN_FALLBACK = 2'd2,
        FN_END      = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_FALLBACK     = 2'd0,
        CFG_FALLBACK_PRESENT = 2'd1,
        CFG_MISSING_MARKER   = 2'd2
    } cfg_idx_t;

endpackage

### sv/dbcs_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read.
// Used for the primary and fallback mapping tables; depends on no package.
module dbcs_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/dbcs_to_unicode_decoder.sv
// Top level of the double-byte charset to 16-bit code unit decoder.
// Depends on dbcs_pkg and dbcs_ram (primary and fallback tables).
// A result passes the table read register and then the output register after its input transfer.
// Throughput: one item per cycle while the result stream is not stalled; each byte pair reads each table RAM once.
// Reset: pending lead and pipeline valids clear at once, config registers take their
// reset values (marker 0xFFFD); table contents are undefined until written, no clearing pass.
module dbcs_to_unicode_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dbcs_pkg::S_TDATA_W-1:0]  s_tdata,   // data_byte, table_index, table_value
    input  logic [dbcs_pkg::FUNC_W-1:0]     s_tuser,   // func
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dbcs_pkg::M_TDATA_W-1:0]  m_tdata,   // code_unit, bad_bytes
    output logic [dbcs_pkg::STATUS_W-1:0]   m_tuser,   // status
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dbcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbcs_pkg::CFG_DATA_W-1:0] cfg_data
);

    import dbcs_pkg::*;

    // Input field unpack
    func_t             in_func;
    logic [BYTE_W-1:0] in_byte;
    logic [KEY_W-1:0]  in_index;
    logic [UNIT_W-1:0] in_value;

    assign in_func  = func_t'(s_tuser);
    assign in_byte  = s_tdata[7:0];
    assign in_index = s_tdata[23:8];
    assign in_value = s_tdata[39:24];

    // Configuration registers
    logic              use_fallback_reg;
    logic              fallback_present_reg;
    logic [UNIT_W-1:0] missing_marker_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_fallback_reg     <= 1'b0;
            fallback_present_reg <= 1'b0;
            missing_marker_reg   <= MISSING_MARKER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_USE_FALLBACK:     use_fallback_reg     <= cfg_data[0];
                CFG_FALLBACK_PRESENT: fallback_present_reg <= cfg_data[0];
                CFG_MISSING_MARKER:   missing_marker_reg   <= cfg_data[UNIT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Handshake and stage control
    logic s1_valid_reg, s1_valid_next;
    logic s1_trunc_reg, s1_trunc_next;
    logic [KEY_W-1:0] s1_key_reg, s1_key_next;
    logic out_valid_reg;
    logic out_free;
    logic s1_advance;
    logic in_xfer;

    assign out_free   = !out_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign in_xfer    = s_tvalid && s_tready;

    // Pending lead and lookup issue
    logic [BYTE_W-1:0] pending_lead_reg, pending_lead_next;
    logic              lead_held;
    logic              do_lookup;
    logic              do_trunc;
    logic [KEY_W-1:0]  lookup_key;

    assign lead_held  = (pending_lead_reg != '0);
    assign lookup_key = {pending_lead_reg, in_byte};
    assign do_lookup  = in_xfer && (in_func == FN_DATA) && lead_held;
    assign do_trunc   = in_xfer && (in_func == FN_END) && lead_held;

    always_comb
    begin
        pending_lead_next = pending_lead_reg;
        if (in_xfer)
        begin
            case (in_func)
                FN_DATA:  pending_lead_next = lead_held ? '0 : in_byte;
                FN_END:   pending_lead_next = '0;
                default:  pending_lead_next = pending_lead_reg;
            endcase
        end
    end

    // Stage 1 bookkeeping: holds the item whose table data is returning
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_trunc_next = s1_trunc_reg;
        s1_key_next   = s1_key_reg;
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (do_lookup || do_trunc)
        begin
            s1_valid_next = 1'b1;
            s1_trunc_next = do_trunc;
            s1_key_next   = do_trunc ? {pending_lead_reg, {BYTE_W{1'b0}}} : lookup_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_lead_reg <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            pending_lead_reg <= pending_lead_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_trunc_reg <= s1_trunc_next;
        s1_key_reg   <= s1_key_next;
    end

    // Mapping tables; a write and a read never share a cycle
    logic [UNIT_W-1:0] prim_rdata;
    logic [UNIT_W-1:0] fb_rdata;

    dbcs_ram #(
        .ADDR_W (KEY_W),
        .DATA_W (UNIT_W)
    ) u_primary (
        .clk   (clk),
        .we    (in_xfer && (in_func == FN_PRIMARY)),
        .waddr (in_index),
        .wdata (in_value),
        .re    (do_lookup),
        .raddr (lookup_key),
        .rdata (prim_rdata)
    );

    dbcs_ram #(
        .ADDR_W (KEY_W),
        .DATA_W (UNIT_W)
    ) u_fallback (
        .clk   (clk),
        .we    (in_xfer && (in_func == FN_FALLBACK)),
        .waddr (in_index),
        .wdata (in_value),
        .re    (do_lookup),
        .raddr (lookup_key),
        .rdata (fb_rdata)
    );

    // Result selection from returned table data
    logic [UNIT_W-1:0] res_unit;
    status_t           res_status;
    logic [KEY_W-1:0]  res_bad;
    logic              prim_hit;
    logic              fb_hit;

    assign prim_hit = (prim_rdata != missing_marker_reg);
    assign fb_hit   = use_fallback_reg && fallback_present_reg
                      && (fb_rdata != missing_marker_reg);

    always_comb
    begin
        res_unit   = '0;
        res_status = ST_OK;
        res_bad    = '0;
        if (s1_trunc_reg)
        begin
            res_status = ST_TRUNCATED;
            res_bad    = s1_key_reg;
        end
        else if (prim_hit)
        begin
            res_unit = prim_rdata;
        end
        else if (fb_hit)
        begin
            res_unit = fb_rdata;
        end
        else
        begin
            res_status = ST_INVALID;
            res_bad    = s1_key_reg;
        end
    end

    // Output register
    logic [UNIT_W-1:0] out_unit_reg;
    status_t           out_status_reg;
    logic [KEY_W-1:0]  out_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_unit_reg   <= res_unit;
            out_status_reg <= res_status;
            out_bad_reg    <= res_bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bad_reg, out_unit_reg};
    assign m_tuser  = out_status_reg;

endmodule

### verif/tb_dbcs_to_unicode_decoder.sv
// Self-checking testbench for dbcs_to_unicode_decoder: byte pairs, table loads, end items.
// Depends on dbcs_pkg and the decoder RTL; keeps its own copy of both tables and the lead.
module tb_dbcs_to_unicode_decoder;

    import dbcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        func_t           fn;
        logic [7:0]      byte_val;
        logic [15:0]     key;
        logic [15:0]     value;
    } stream_item_t;

    typedef struct {
        logic [15:0]     unit;
        status_t         status;
        logic [15:0]     bad;
    } decode_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // data_byte, table_index, table_value
    logic [FUNC_W-1:0]     s_tuser = '0;   // func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // code_unit, bad_bytes
    logic [STATUS_W-1:0]   m_tuser;        // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dbcs_to_unicode_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Stimulus plumbing
    stream_item_t   pending_items[$];
    decode_result_t expected_units[$];
    int unsigned    pushed_count = 0;
    int unsigned    accepted_count = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    bit             in_taken = 1'b0;
    bit             cfg_taken = 1'b0;

    // Decoder copy, updated on accepted transfers
    logic [7:0]  held_lead = 8'h00;
    logic [15:0] primary_map [0:65535];
    logic [15:0] fallback_map [0:65535];
    logic        fb_enable = 1'b0;
    logic        fb_loaded = 1'b0;
    logic [15:0] no_map_marker = MISSING_MARKER_RST;

    // Generator view: which keys may be read safely
    logic [7:0]  gen_lead = 8'h00;
    logic [15:0] gen_marker = MISSING_MARKER_RST;
    bit          pri_written [0:65535];
    bit          fb_written [0:65535];
    bit          key_readable [0:65535];
    logic [15:0] readable_keys[$];

    // Statistics
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned ok_count = 0;
    int unsigned invalid_count = 0;
    int unsigned trunc_count = 0;
    int unsigned setting_count = 1;

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predict one accepted item
    function automatic void decode_step(func_t fn, logic [7:0] b, logic [15:0] idx,
                                        logic [15:0] val);
        decode_result_t r;
        logic [15:0]    key;
        logic [15:0]    v;
        case (fn)
            FN_PRIMARY:  primary_map[idx] = val;
            FN_FALLBACK: fallback_map[idx] = val;
            FN_END:
            begin
                if (held_lead != 8'h00)
                begin
                    r.unit = 16'h0000;
                    r.status = ST_TRUNCATED;
                    r.bad = {held_lead, 8'h00};
                    expected_units.push_back(r);
                    held_lead = 8'h00;
                end
            end
            default:
            begin
                // zero byte with nothing held stays "nothing held"
                if (held_lead == 8'h00)
                    held_lead = b;
                else
                begin
                    key = {held_lead, b};
                    held_lead = 8'h00;
                    v = primary_map[key];
                    if (v == no_map_marker && fb_enable && fb_loaded)
                        v = fallback_map[key];
                    if (v != no_map_marker)
                    begin
                        r.unit = v;
                        r.status = ST_OK;
                        r.bad = 16'h0000;
                    end
                    else
                    begin
                        r.unit = 16'h0000;
                        r.status = ST_INVALID;
                        r.bad = key;
                    end
                    expected_units.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic report_failure(string what, decode_result_t exp_r, decode_result_t got_r);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected unit=%h status=%0d bad=%h, got unit=%h status=%0d bad=%h",
                     $realtime, what, exp_r.unit, exp_r.status, exp_r.bad,
                     got_r.unit, got_r.status, got_r.bad);
    endtask

    // Input, config and result monitor
    always @(posedge clk)
    begin : transfer_monitor
        decode_result_t got_r;
        decode_result_t exp_r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                accepted_count++;
                decode_step(func_t'(s_tuser), s_tdata[7:0], s_tdata[23:8], s_tdata[39:24]);
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_taken = 1'b1;
                case (cfg_idx_t'(cfg_index))
                    CFG_USE_FALLBACK:     fb_enable = cfg_data[0];
                    CFG_FALLBACK_PRESENT: fb_loaded = cfg_data[0];
                    CFG_MISSING_MARKER:   no_map_marker = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got_r.unit = m_tdata[15:0];
                got_r.bad = m_tdata[31:16];
                got_r.status = status_t'(m_tuser);
                if (expected_units.size() == 0)
                begin
                    exp_r = '{unit: 16'h0, status: ST_OK, bad: 16'h0};
                    report_failure("result with none pending", exp_r, got_r);
                end
                else
                begin
                    exp_r = expected_units.pop_front();
                    if (got_r.unit !== exp_r.unit || got_r.status !== exp_r.status ||
                        got_r.bad !== exp_r.bad)
                        report_failure("field mismatch", exp_r, got_r);
                    case (exp_r.status)
                        ST_OK:      ok_count++;
                        ST_INVALID: invalid_count++;
                        default:    trunc_count++;
                    endcase
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stream driver and result backpressure
    always @(negedge clk)
    begin : stream_driver
        stream_item_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {nxt.value, nxt.key, nxt.byte_val};
                s_tuser <= nxt.fn;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Queue helpers; unused fields carry random noise
    task automatic push_item(func_t fn, logic [7:0] b, logic [15:0] idx, logic [15:0] val);
        stream_item_t it;
        it.fn = fn;
        it.byte_val = b;
        it.key = idx;
        it.value = val;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    task automatic push_byte(logic [7:0] b);
        push_item(FN_DATA, b, 16'($urandom), 16'($urandom));
        gen_lead = (gen_lead == 8'h00) ? b : 8'h00;
    endtask

    task automatic push_end();
        push_item(FN_END, 8'($urandom), 16'($urandom), 16'($urandom));
        gen_lead = 8'h00;
    endtask

    task automatic push_write(func_t fn, logic [15:0] idx, logic [15:0] val);
        push_item(fn, 8'($urandom), idx, val);
        if (fn == FN_PRIMARY)
            pri_written[idx] = 1'b1;
        else
            fb_written[idx] = 1'b1;
        // only keys with both tables loaded and a nonzero lead are read
        if (pri_written[idx] && fb_written[idx] && idx[15:8] != 8'h00 && !key_readable[idx])
        begin
            key_readable[idx] = 1'b1;
            readable_keys.push_back(idx);
        end
    endtask

    function automatic logic [15:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return gen_marker;
        else if (r < 40)
            return 16'h0000;
        else if (r < 50)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_key();
        return readable_keys[$urandom_range(0, readable_keys.size() - 1)];
    endfunction

    // Random sequences; each starts and ends with no lead held
    task automatic fill_random(int unsigned n);
        int unsigned start;
        int unsigned r;
        logic [15:0] k;
        start = pushed_count;
        while (pushed_count - start < n)
        begin
            r = $urandom_range(0, 99);
            if (readable_keys.size() == 0 || r < 15)
            begin
                k = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
                if ($urandom_range(0, 1))
                begin
                    push_write(FN_PRIMARY, k, pick_value());
                    push_write(FN_FALLBACK, k, pick_value());
                end
                else
                begin
                    push_write(FN_FALLBACK, k, pick_value());
                    push_write(FN_PRIMARY, k, pick_value());
                end
            end
            else if (r < 60)
            begin
                k = pick_key();
                push_byte(k[15:8]);
                push_byte(k[7:0]);
            end
            else if (r < 68)
            begin
                // table load lands between lead and trail
                k = pick_key();
                push_byte(k[15:8]);
                if ($urandom_range(0, 1))
                    push_write($urandom_range(0, 1) ? FN_PRIMARY : FN_FALLBACK, k, pick_value());
                else
                    push_write($urandom_range(0, 1) ? FN_PRIMARY : FN_FALLBACK,
                               16'($urandom), pick_value());
                push_byte(k[7:0]);
            end
            else if (r < 76)
            begin
                push_byte(8'($urandom_range(1, 255)));
                if ($urandom_range(0, 2) == 0)
                    push_write(FN_FALLBACK, 16'($urandom), 16'($urandom));
                push_end();
            end
            else if (r < 80)
                push_end();
            else if (r < 85)
            begin
                k = pick_key();
                push_byte(8'h00);
                push_byte(k[15:8]);
                push_byte(k[7:0]);
            end
            else if (r < 92)
                push_write($urandom_range(0, 1) ? FN_PRIMARY : FN_FALLBACK,
                           16'($urandom), 16'($urandom));
            else
            begin
                // force a missing primary mapping so the fallback path is taken when enabled
                k = pick_key();
                push_write(FN_PRIMARY, k, gen_marker);
                push_byte(k[15:8]);
                push_byte(k[7:0]);
            end
        end
    endtask

    // Wait until every item went in and every result came out
    task automatic wait_drained();
        while (accepted_count != pushed_count || expected_units.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_taken = 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_setting(logic use_fb, logic present, logic [15:0] marker,
                               int unsigned idle_pct, int unsigned stall_pct);
        write_reg(CFG_USE_FALLBACK, {15'h0, use_fb});
        write_reg(CFG_FALLBACK_PRESENT, {15'h0, present});
        write_reg(CFG_MISSING_MARKER, marker);
        gen_marker = marker;
        setting_count++;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        // sender holds off halfway until the result stream is empty
        fill_random(50);
        wait_drained();
        fill_random(50);
        wait_drained();
    endtask

    // Main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset config, zero trail, all-ones key, ignored zero lead,
        // truncation, bare end, load between lead and trail
        push_write(FN_PRIMARY, 16'h0100, 16'h1234);
        push_write(FN_FALLBACK, 16'h0100, 16'h5678);
        push_write(FN_PRIMARY, 16'hFF00, MISSING_MARKER_RST);
        push_write(FN_FALLBACK, 16'hFF00, 16'h0000);
        push_write(FN_PRIMARY, 16'hFFFF, 16'hFFFF);
        push_write(FN_FALLBACK, 16'hFFFF, 16'hABCD);
        push_write(FN_PRIMARY, 16'h01FF, 16'h0000);
        push_write(FN_FALLBACK, 16'h01FF, 16'h0001);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_end();
        push_end();
        push_byte(8'h01);
        push_write(FN_PRIMARY, 16'h0100, 16'h4321);
        push_write(FN_FALLBACK, 16'h0100, 16'h8765);
        push_byte(8'h00);
        wait_drained();

        // Random settings, extremes of the marker included
        run_setting(1'b1, 1'b1, 16'hFFFD, 0, 0);
        run_setting(1'b1, 1'b0, 16'h0000, 82, 0);
        run_setting(1'b0, 1'b1, 16'hFFFF, 0, 82);
        run_setting(1'b1, 1'b1, 16'h0000, 16, 16);
        run_setting(1'b1, 1'b1, 16'hFFFF, 82, 0);
        run_setting(1'b1, 1'b1, 16'($urandom), 0, 82);
        run_setting(1'b0, 1'b0, 16'($urandom), 16, 16);

        while (expected_units.size() != 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("Result never arrived: unit=%h status=%0d bad=%h",
                         expected_units[0].unit, expected_units[0].status,
                         expected_units[0].bad);
            void'(expected_units.pop_front());
        end

        $display("Ran %0d input transfers under %0d register settings in %0d cycles",
                 accepted_count, setting_count, cycle_count);
        $display("Checked %0d decoded, %0d invalid pair, %0d truncated lead results",
                 ok_count, invalid_count, trunc_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
